>>> hw/rtl/ip_address_literal_recognizer_unit_assert.svh
// ----------------------------------------------------------------------------
// IP address literal recognizer assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_LITERAL_RECOGNIZER_UNIT_ASSERT_SVH
`define IP_ADDRESS_LITERAL_RECOGNIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define IPLR_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |-> (cons)) \
    else $error("iplr assertion failed");
`define IPLR_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |=> (cons)) \
    else $error("iplr assertion failed");
`else
`define IPLR_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons)
`define IPLR_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

>>> hw/rtl/iplr_pkg.sv
// ----------------------------------------------------------------------------
// IP address literal recognizer package
// Shared types, character codes and limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iplr_pkg;

  typedef enum logic [2:0] {
    PH_V4,
    PH_HEX,
    PH_COLON,
    PH_TAIL,
    PH_ACCEPT,
    PH_REJECT
  } iplr_phase_t;

  typedef struct packed {
    iplr_phase_t phase;
    logic [2:0]  groups;
    logic [2:0]  dec_len;
    logic [9:0]  dec_val;
    logic [2:0]  hex_len;
    logic        all_dec;
    logic [1:0]  colon_len;
    logic [3:0]  colon_tot;
    logic        dbl_colon;
  } iplr_state_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        char_present;
    logic        literal_kind;
    logic        first_char;
    logic        last_char;
  } iplr_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] consumed;
  } iplr_result_t;

  localparam logic [20:0] CH_DOT    = 21'h00002E;
  localparam logic [20:0] CH_COLON  = 21'h00003A;
  localparam logic [20:0] CH_ZERO   = 21'h000030;
  localparam logic [20:0] CH_NINE   = 21'h000039;
  localparam logic [20:0] CH_LO_A   = 21'h000061;
  localparam logic [20:0] CH_LO_F   = 21'h000066;
  localparam logic [20:0] CH_UP_A   = 21'h000041;
  localparam logic [20:0] CH_UP_F   = 21'h000046;

  localparam logic [2:0] GROUPS_NEEDED = 3'd4;
  localparam logic [2:0] DEC_RUN_MAX   = 3'd3;
  localparam logic [2:0] DEC_RUN_OVER  = 3'd4;
  localparam logic [2:0] HEX_RUN_MAX   = 3'd4;
  localparam logic [9:0] OCTET_MAX     = 10'd255;
  localparam logic [3:0] COLON_MIN     = 4'd2;
  localparam logic [3:0] COLON_LIM_DBL = 4'd6;
  localparam logic [3:0] COLON_LIM     = 4'd7;
  localparam logic [3:0] COLON_SAT     = 4'd15;
  localparam logic [1:0] COLON_RUN_MAX = 2'd2;

  function automatic iplr_state_t iplr_clear_state(iplr_phase_t ph);
    iplr_state_t s;
    s.phase     = ph;
    s.groups    = '0;
    s.dec_len   = '0;
    s.dec_val   = '0;
    s.hex_len   = '0;
    s.all_dec   = 1'b1;
    s.colon_len = '0;
    s.colon_tot = '0;
    s.dbl_colon = 1'b0;
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/iplr_step.sv
// ----------------------------------------------------------------------------
// IP address literal recognizer step logic
// Next parse state, character count and verdict for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iplr_step
  import iplr_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  wire iplr_state_t                 state_i,
  input  wire logic [COUNT_BITS-1:0]       count_i,
  input  wire iplr_item_t                  item_i,
  output iplr_state_t                      state_o,
  output logic [COUNT_BITS-1:0]            count_o,
  output iplr_result_t                     result_o
);

  typedef struct packed {
    iplr_state_t st;
    logic        take;
  } step_t;

  function automatic logic is_dec(logic [20:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(logic [20:0] c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic iplr_state_t v6_close(iplr_state_t s);
    iplr_state_t r;
    logic        ok;
    r = s;
    if (s.colon_tot < COLON_MIN) begin
      ok = 1'b0;
    end else if (s.dbl_colon) begin
      ok = s.colon_tot < COLON_LIM_DBL;
    end else begin
      ok = s.colon_tot < COLON_LIM;
    end
    r.phase = ok ? PH_ACCEPT : PH_REJECT;
    return r;
  endfunction

  function automatic iplr_state_t group_done(iplr_state_t s);
    iplr_state_t r;
    r = s;
    r.groups = s.groups + 3'd1;
    if (r.groups >= GROUPS_NEEDED) begin
      if (s.phase == PH_TAIL) begin
        r = v6_close(r);
      end else begin
        r.phase = PH_ACCEPT;
      end
    end
    return r;
  endfunction

  function automatic step_t v4_char(iplr_state_t s, logic [20:0] c);
    step_t       r;
    logic [13:0] v;
    r.st   = s;
    r.take = 1'b0;
    v = 14'(s.dec_val) * 14'd10 + 14'(c[3:0]);
    if (is_dec(c)) begin
      if (s.dec_len >= DEC_RUN_MAX) begin
        r.st.phase = PH_REJECT;
      end else if (v > 14'(OCTET_MAX)) begin
        r.st.phase = PH_REJECT;
      end else begin
        r.st.dec_val = v[9:0];
        r.st.dec_len = s.dec_len + 3'd1;
        r.take       = 1'b1;
      end
    end else if (s.dec_len == '0) begin
      r.st.phase = PH_REJECT;
    end else begin
      r.st = group_done(s);
      if (r.st.groups < GROUPS_NEEDED) begin
        if (c == CH_DOT) begin
          r.take       = 1'b1;
          r.st.dec_len = '0;
          r.st.dec_val = '0;
        end else begin
          r.st.phase = PH_REJECT;
        end
      end
    end
    return r;
  endfunction

  function automatic iplr_state_t v4_end(iplr_state_t s);
    iplr_state_t r;
    r = s;
    if (s.dec_len == '0) begin
      r.phase = PH_REJECT;
    end else begin
      r = group_done(s);
      if (r.groups < GROUPS_NEEDED) begin
        r.phase = PH_REJECT;
      end
    end
    return r;
  endfunction

  function automatic step_t hex_char(iplr_state_t s, logic [20:0] c);
    step_t       r;
    logic [13:0] v;
    r.st   = s;
    r.take = 1'b0;
    v = 14'(s.dec_val) * 14'd10 + 14'(c[3:0]);
    if (is_hex(c)) begin
      if (s.hex_len >= HEX_RUN_MAX) begin
        r.st.phase = PH_REJECT;
      end else begin
        r.st.hex_len = s.hex_len + 3'd1;
        r.take       = 1'b1;
        if (!is_dec(c)) begin
          r.st.all_dec = 1'b0;
        end else if (s.all_dec) begin
          if (s.dec_len < DEC_RUN_MAX) begin
            r.st.dec_val = v[9:0];
            r.st.dec_len = s.dec_len + 3'd1;
          end else begin
            r.st.dec_len = DEC_RUN_OVER;
          end
        end
      end
    end else if ((c == CH_DOT) && (s.hex_len != '0) && (s.colon_tot > COLON_MIN)) begin
      if (s.all_dec && (s.dec_len <= DEC_RUN_MAX) && (s.dec_val <= OCTET_MAX)) begin
        r.take       = 1'b1;
        r.st.phase   = PH_TAIL;
        r.st.groups  = 3'd1;
        r.st.dec_len = '0;
        r.st.dec_val = '0;
      end else begin
        r.st.phase = PH_REJECT;
      end
    end else if (c == CH_COLON) begin
      r.take         = 1'b1;
      r.st.phase     = PH_COLON;
      r.st.colon_len = 2'd1;
      if (s.colon_tot < COLON_SAT) begin
        r.st.colon_tot = s.colon_tot + 4'd1;
      end
    end else begin
      r.st = v6_close(s);
    end
    return r;
  endfunction

  function automatic step_t colon_char(iplr_state_t s, logic [20:0] c);
    step_t       r;
    iplr_state_t t;
    r.st   = s;
    r.take = 1'b0;
    t      = s;
    if (c == CH_COLON) begin
      if ((s.colon_len >= COLON_RUN_MAX) || s.dbl_colon) begin
        r.st.phase = PH_REJECT;
      end else begin
        r.take         = 1'b1;
        r.st.colon_len = COLON_RUN_MAX;
        r.st.dbl_colon = 1'b1;
        if (s.colon_tot < COLON_SAT) begin
          r.st.colon_tot = s.colon_tot + 4'd1;
        end
      end
    end else begin
      t.phase     = PH_HEX;
      t.colon_len = '0;
      t.hex_len   = '0;
      t.all_dec   = 1'b1;
      t.dec_len   = '0;
      t.dec_val   = '0;
      r = hex_char(t, c);
    end
    return r;
  endfunction

  iplr_state_t           st_base;
  step_t                 st_char;
  iplr_state_t           st_end;
  logic [COUNT_BITS-1:0] cnt_base;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [15:0]           cnt_wide;

  always_comb begin
    if (item_i.first_char) begin
      st_base  = iplr_clear_state(item_i.literal_kind ? PH_HEX : PH_V4);
      cnt_base = '0;
    end else begin
      st_base  = state_i;
      cnt_base = count_i;
    end

    st_char.st   = st_base;
    st_char.take = 1'b0;
    if (item_i.char_present) begin
      case (st_base.phase)
        PH_V4:    st_char = v4_char(st_base, item_i.code_point);
        PH_TAIL:  st_char = v4_char(st_base, item_i.code_point);
        PH_HEX:   st_char = hex_char(st_base, item_i.code_point);
        PH_COLON: st_char = colon_char(st_base, item_i.code_point);
        default:  st_char.st = st_base;
      endcase
    end

    cnt_next = cnt_base;
    if (st_char.take && (cnt_base != {COUNT_BITS{1'b1}})) begin
      cnt_next = cnt_base + COUNT_BITS'(1);
    end
    cnt_wide = 16'(cnt_next);

    st_end = st_char.st;
    if (item_i.last_char) begin
      case (st_char.st.phase)
        PH_V4:    st_end = v4_end(st_char.st);
        PH_TAIL:  st_end = v4_end(st_char.st);
        PH_HEX:   st_end = v6_close(st_char.st);
        PH_COLON: st_end = v6_close(st_char.st);
        default:  st_end = st_char.st;
      endcase
    end

    result_o.accepted = 1'b0;
    result_o.consumed = '0;
    if (item_i.last_char) begin
      if (st_end.phase == PH_ACCEPT) begin
        result_o.accepted = 1'b1;
        result_o.consumed = (cnt_wide > 16'd255) ? 8'hFF : cnt_wide[7:0];
      end else begin
        st_end.phase = PH_REJECT;
      end
    end

    state_o = st_end;
    count_o = cnt_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ip_address_literal_recognizer_unit.sv
// A result is registered once its last item leaves the input register through the parse step.
// Throughput: one item per cycle through the parse step between the input register and the
// result register, except that a last item waits while an earlier result is not yet taken.
// Reset: synchronous, active low; clears both valid flags, the character count
// and the parse state to the IPv4 groups phase.
// ----------------------------------------------------------------------------
// IP address literal recognizer
// Streams literal text one character per item, gives accept and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ip_address_literal_recognizer_unit_assert.svh"

module ip_address_literal_recognizer_unit
  import iplr_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [20:0] code_point
  input  wire logic [2:0]  in_tuser,   // [0] char_present, [1] literal_kind, [2] first_char
  input  wire logic        in_tlast,   // last_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] consumed
  output logic [0:0]       out_tuser   // [0] accepted
);

  logic                  s1_valid_r;
  iplr_item_t            s1_item_r;
  iplr_state_t           state_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  out_valid_r;
  iplr_result_t          out_res_r;

  iplr_state_t           state_nxt;
  logic [COUNT_BITS-1:0] count_nxt;
  iplr_result_t          res_nxt;
  logic                  advance;
  logic                  in_fire;

  assign advance   = s1_valid_r && (!s1_item_r.last_char || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  iplr_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .state_i  (state_r),
    .count_i  (count_r),
    .item_i   (s1_item_r),
    .state_o  (state_nxt),
    .count_o  (count_nxt),
    .result_o (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= iplr_clear_state(PH_V4);
      count_r     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        state_r <= state_nxt;
        count_r <= count_nxt;
      end
      if (advance && s1_item_r.last_char) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.code_point   <= in_tdata[20:0];
      s1_item_r.char_present <= in_tuser[0];
      s1_item_r.literal_kind <= in_tuser[1];
      s1_item_r.first_char   <= in_tuser[2];
      s1_item_r.last_char    <= in_tlast;
    end
    if (advance && s1_item_r.last_char) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_res_r.consumed;
  assign out_tuser[0] = out_res_r.accepted;

  `IPLR_ASSERT_SAME(a_reject_zero_len, clk, rst_n,
    out_valid_r && !out_res_r.accepted, out_res_r.consumed == 8'd0)
  `IPLR_ASSERT_NEXT(a_verdict_final, clk, rst_n, advance && s1_item_r.last_char,
    (state_r.phase == PH_ACCEPT) || (state_r.phase == PH_REJECT))
  `IPLR_ASSERT_NEXT(a_no_spurious_out, clk, rst_n,
    advance && !s1_item_r.last_char && !out_valid_r, !out_valid_r)
  `IPLR_ASSERT_NEXT(a_count_monotonic, clk, rst_n,
    advance && !s1_item_r.first_char, count_r >= $past(count_r))

endmodule

`default_nettype wire
